@@ hdl/ffdf_pkg.sv @@
`default_nettype none
package ffdf_pkg;

  localparam int SEEN_DEPTH = 64;
  localparam int MAX_NODES  = 64;

  localparam int ADDR_W = $clog2(SEEN_DEPTH);
  localparam int CNT_W  = $clog2(SEEN_DEPTH + 1);

  localparam int ID_W      = 6;
  localparam int SEQ_W     = 31;
  localparam int PAYLOAD_W = 32;
  localparam int MASK_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int TDATA_W   = 72;
  localparam int TUSER_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PAYLOAD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ENABLE  = 2'd3;

  typedef enum logic [2:0] {
    RSN_FORWARD  = 3'd0,
    RSN_OWN      = 3'd1,
    RSN_NEIGHBOR = 3'd2,
    RSN_SEEN     = 3'd3,
    RSN_FULL     = 3'd4
  } reason_t;

  typedef struct packed {
    logic start;
    logic commit;
  } seen_req_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic full;
  } seen_rsp_t;

endpackage
`default_nettype wire

@@ hdl/flood_forward_dedup_filter.sv @@
`default_nettype none
// channel  | dir | handshake                | payload
// s_       | in  | s_tvalid / s_tready      | s_tdata: received message
// m_       | out | m_tvalid / m_tready      | m_tdata: forwarded copy, m_tuser: verdict
// cfg_     | in  | cfg_we                   | cfg_index, cfg_data
//
// one message at a time: the time from accept to result grows with seen_count,
// set by the linear scan through the seen store, one entry per cycle from its
// single read port. own payload and neighbour drops skip the scan.
// synchronous reset empties the store at once by clearing the fill count.
// a waiting result in the output register holds back the next verdict only.
module flood_forward_dedup_filter
  import ffdf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // msg_source[5:0], msg_sequence[36:6], msg_payload[68:37], zero fill
  input  wire logic [TDATA_W-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // out_source[5:0], out_sequence[36:6], out_payload[68:37], zero fill
  output logic [TDATA_W-1:0]        m_tdata,
  // forward[0], drop_reason[3:1]
  output logic [TUSER_W-1:0]        m_tuser,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ID_W-1:0]      node_id;
  logic [MASK_W-1:0]    neighbor_mask;
  logic [PAYLOAD_W-1:0] own_payload;
  logic                 own_payload_enable;

  logic [ID_W-1:0]      src;
  logic [SEQ_W-1:0]     seq;
  logic [PAYLOAD_W-1:0] pay;
  reason_t              reason;
  reason_t              reason_next;

  seen_req_t req;
  seen_rsp_t rsp;

  logic in_fire;
  logic out_load;
  logic own_drop;
  logic nb_ok;
  logic [SEQ_W-1:0] seq_inc;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign own_drop = own_payload_enable && (pay == own_payload);
  assign nb_ok    = (32'(src) < MAX_NODES) && neighbor_mask[src];
  assign seq_inc  = (seq == '1) ? seq : seq + SEQ_W'(1);

  ffdf_seen_store u_seen (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .payload (pay),
    .rsp     (rsp)
  );

  always_comb begin
    state_next  = state;
    reason_next = reason;
    req.start   = 1'b0;
    req.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (own_drop) begin
          reason_next = RSN_OWN;
          state_next  = ST_OUT;
        end else if (!nb_ok) begin
          reason_next = RSN_NEIGHBOR;
          state_next  = ST_OUT;
        end else begin
          req.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rsp.done) begin
          state_next = ST_OUT;
          if (rsp.hit) begin
            reason_next = RSN_SEEN;
          end else if (rsp.full) begin
            reason_next = RSN_FULL;
          end else begin
            reason_next = RSN_FORWARD;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          req.commit = (reason == RSN_FORWARD);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      reason             <= RSN_FORWARD;
      m_tvalid           <= 1'b0;
      node_id            <= '0;
      neighbor_mask      <= '0;
      own_payload        <= '0;
      own_payload_enable <= 1'b0;
    end else begin
      state  <= state_next;
      reason <= reason_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_ID:     node_id            <= cfg_data[ID_W-1:0];
          CFG_NEIGHBOR:    neighbor_mask      <= cfg_data[MASK_W-1:0];
          CFG_OWN_PAYLOAD: own_payload        <= cfg_data[PAYLOAD_W-1:0];
          CFG_OWN_ENABLE:  own_payload_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      src <= s_tdata[ID_W-1:0];
      seq <= s_tdata[ID_W+SEQ_W-1:ID_W];
      pay <= s_tdata[ID_W+SEQ_W+PAYLOAD_W-1:ID_W+SEQ_W];
    end
    if (out_load) begin
      if (reason == RSN_FORWARD) begin
        m_tdata <= {(TDATA_W-ID_W-SEQ_W-PAYLOAD_W)'(0), pay, seq_inc, node_id};
        m_tuser <= {reason, 1'b1};
      end else begin
        m_tdata <= '0;
        m_tuser <= {reason, 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/ffdf_seen_store.sv @@
`default_nettype none
module ffdf_seen_store
  import ffdf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire seen_req_t            req,
  input  wire logic [PAYLOAD_W-1:0] payload,
  output seen_rsp_t                 rsp
);

  logic [PAYLOAD_W-1:0] mem [SEEN_DEPTH];
  logic [PAYLOAD_W-1:0] mem_q;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rd_addr;
  logic                 busy;
  logic                 pend;
  logic                 hit_now;
  logic                 issue;
  logic                 done;

  assign hit_now = busy && pend && (mem_q == payload);
  assign issue   = busy && !hit_now && (rd_addr < count);
  assign done    = busy && (hit_now || (!pend && (rd_addr >= count)));

  assign rsp.done = done;
  assign rsp.hit  = hit_now;
  assign rsp.full = (count >= CNT_W'(SEEN_DEPTH));

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_q <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.commit) begin
      mem[count[ADDR_W-1:0]] <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pend    <= 1'b0;
      rd_addr <= '0;
      count   <= '0;
    end else begin
      pend <= issue;
      if (req.start) begin
        busy    <= 1'b1;
        rd_addr <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (issue) begin
        rd_addr <= rd_addr + CNT_W'(1);
      end
      if (req.commit) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
